/* rtl/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg
// shared widths, types and exp tables of the five-way softmax
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int CHOICES   = 5;
  localparam int SCORE_W   = 16;
  localparam int SUM_W     = 17;
  localparam int DIST_W    = 17;
  localparam int BETA_W    = 15;
  localparam int PROB_W    = 17;
  localparam int TOT_W     = 19;
  localparam int NUM_W     = 33;
  localparam int EXP_LIMIT = 12;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [DIST_W-1:0]       dist_t;
  typedef logic [PROB_W-1:0]       prob_t;
  typedef logic [TOT_W-1:0]        tot_t;
  typedef logic [NUM_W-1:0]        num_t;

  // exp(-n), Q0.24
  function automatic logic [24:0] expi(input logic [3:0] n);
    logic [24:0] v;
    case (n)
      4'd0:    v = 25'd16777216;
      4'd1:    v = 25'd6171993;
      4'd2:    v = 25'd2270549;
      4'd3:    v = 25'd835288;
      4'd4:    v = 25'd307285;
      4'd5:    v = 25'd113044;
      4'd6:    v = 25'd41587;
      4'd7:    v = 25'd15299;
      4'd8:    v = 25'd5628;
      4'd9:    v = 25'd2070;
      4'd10:   v = 25'd762;
      4'd11:   v = 25'd280;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

  // exp(-j/16), Q0.16
  function automatic logic [16:0] expa(input logic [3:0] j);
    logic [16:0] v;
    case (j)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61566;
      4'd2:    v = 17'd57836;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  // exp(-j/256), Q0.16
  function automatic logic [16:0] expb(input logic [3:0] j);
    logic [16:0] v;
    case (j)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd65280;
      4'd2:    v = 17'd65026;
      4'd3:    v = 17'd64772;
      4'd4:    v = 17'd64520;
      4'd5:    v = 17'd64268;
      4'd6:    v = 17'd64018;
      4'd7:    v = 17'd63768;
      4'd8:    v = 17'd63520;
      4'd9:    v = 17'd63272;
      4'd10:   v = 17'd63025;
      4'd11:   v = 17'd62780;
      4'd12:   v = 17'd62535;
      4'd13:   v = 17'd62291;
      4'd14:   v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

endpackage

/* rtl/smx_exp_lane.sv */
// ----------------------------------------------------------------------------
// smx_exp_lane
// one lane: gain multiply and table exp, four register stages
// ----------------------------------------------------------------------------
module smx_exp_lane (
  input  logic                          clk,
  input  logic                          en,
  input  smx_pkg::dist_t                gap,
  input  logic [smx_pkg::BETA_W-1:0]    beta,
  output smx_pkg::prob_t                term
);

  logic [31:0] t_nxt;
  logic        deep_a_r, deep_b_r, deep_c_r;
  logic [3:0]  n_a_r;
  logic [15:0] f_a_r;
  logic [11:0] f_b_r;
  logic [7:0]  f_c_r;
  logic [41:0] p1, p2, p3;
  logic [24:0] v1_nxt, v2_nxt, v3;
  logic [24:0] v1_r, v2_r;
  logic [16:0] lin;
  logic [24:0] rnd;
  smx_pkg::prob_t term_r, term_nxt;

  assign t_nxt  = 32'(gap) * 32'(beta);
  assign p1     = 42'(smx_pkg::expi(n_a_r)) * 42'(smx_pkg::expa(f_a_r[15:12])) + 42'd32768;
  assign v1_nxt = p1[40:16];
  assign p2     = 42'(v1_r) * 42'(smx_pkg::expb(f_b_r[11:8])) + 42'd32768;
  assign v2_nxt = p2[40:16];
  assign lin    = 17'd65536 - 17'(f_c_r);
  assign p3     = 42'(v2_r) * 42'(lin) + 42'd32768;
  assign v3     = p3[40:16];
  assign rnd    = v3 + 25'd128;
  assign term_nxt = deep_c_r ? '0 : rnd[24:8];

  always_ff @(posedge clk) begin
    if (en) begin
      deep_a_r <= (t_nxt[31:16] >= 16'(smx_pkg::EXP_LIMIT));
      n_a_r    <= t_nxt[19:16];
      f_a_r    <= t_nxt[15:0];
      deep_b_r <= deep_a_r;
      f_b_r    <= f_a_r[11:0];
      v1_r     <= v1_nxt;
      deep_c_r <= deep_b_r;
      f_c_r    <= f_b_r[7:0];
      v2_r     <= v2_nxt;
      term_r   <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

/* rtl/smx_div.sv */
// ----------------------------------------------------------------------------
// smx_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module smx_div (
  input  logic           clk,
  input  logic           en,
  input  smx_pkg::num_t  num,
  input  smx_pkg::tot_t  den,
  output smx_pkg::prob_t quot
);

  localparam int QW = smx_pkg::PROB_W;
  localparam int DW = smx_pkg::TOT_W;

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] den_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [QW-1:0] lo_in, q_in;
    logic [DW:0]   rs;
    logic          ge;
    logic [DW:0]   diff;
    if (k == 0) begin : g_first
      assign rem_in = DW'(num[smx_pkg::NUM_W-1:QW]);
      assign lo_in  = num[QW-1:0];
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
    end
    assign rs   = {rem_in, lo_in[QW-1]};
    assign ge   = rs >= {1'b0, den_in};
    assign diff = rs - {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : rs[DW-1:0];
        lo_r[k]  <= {lo_in[QW-2:0], 1'b0};
        q_r[k]   <= {q_in[QW-2:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  assign quot = q_r[QW-1];

endmodule

/* rtl/softmax_five_way.sv */
// ----------------------------------------------------------------------------
// softmax_five_way
// five-way softmax with inverse temperature, Q8.8 in, Q0.16 out
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with five scores and five offsets;
//   a transfer happens on a clock edge with in_valid high and in_stall low
//   result channel: out_valid / out_stall with five probabilities prob_0..4
//   cfg_write_enable / cfg_write_data load the inverse temperature (q8.8);
//   write it only while no transfer is in flight
// throughput: one transfer per cycle, from five exp lanes and two
//   pipelined 17-stage dividers running every cycle
// latency: out_valid rises 41 cycles after the input transfer when nothing
//   stalls (input stage loaded at the transfer edge, then max/distance,
//   4 exp stages, 17 divide, renormalize stage, 17 divide, output register)
// reset: rst_n low empties the pipe and the skid slot and sets the gain to 1.0
// stall: while out_stall holds a waiting result the whole pipe freezes;
//   one more input transfer is caught in a skid slot, then in_stall rises
// ----------------------------------------------------------------------------
module softmax_five_way (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_enable,
  input  logic [smx_pkg::BETA_W-1:0]    cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_score_0,
  input  logic signed [15:0]            in_score_1,
  input  logic signed [15:0]            in_score_2,
  input  logic signed [15:0]            in_score_3,
  input  logic signed [15:0]            in_score_4,
  input  logic signed [15:0]            in_offset_0,
  input  logic signed [15:0]            in_offset_1,
  input  logic signed [15:0]            in_offset_2,
  input  logic signed [15:0]            in_offset_3,
  input  logic signed [15:0]            in_offset_4,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [16:0]                   out_prob_0,
  output logic [16:0]                   out_prob_1,
  output logic [16:0]                   out_prob_2,
  output logic [16:0]                   out_prob_3,
  output logic [16:0]                   out_prob_4
);

  localparam int N   = smx_pkg::CHOICES;
  localparam int LAT = 41;   // stages ahead of the output register

  // gain register
  logic [smx_pkg::BETA_W-1:0] beta_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= smx_pkg::BETA_W'(256);
    end else if (cfg_write_enable) begin
      beta_r <= cfg_write_data;
    end
  end

  // pipe advances unless a result waits on a stalled receiver
  logic en;
  logic out_valid_r;
  assign en = !(out_valid_r && out_stall);

  // input sums, straight from the ports
  smx_pkg::sum_t in_sum [N];
  assign in_sum[0] = smx_pkg::SUM_W'(in_score_0) + smx_pkg::SUM_W'(in_offset_0);
  assign in_sum[1] = smx_pkg::SUM_W'(in_score_1) + smx_pkg::SUM_W'(in_offset_1);
  assign in_sum[2] = smx_pkg::SUM_W'(in_score_2) + smx_pkg::SUM_W'(in_offset_2);
  assign in_sum[3] = smx_pkg::SUM_W'(in_score_3) + smx_pkg::SUM_W'(in_offset_3);
  assign in_sum[4] = smx_pkg::SUM_W'(in_score_4) + smx_pkg::SUM_W'(in_offset_4);

  // skid slot catches one transfer while the pipe is frozen
  logic          skid_valid_r;
  smx_pkg::sum_t skid_r [N];
  smx_pkg::sum_t sum_r  [N];
  logic [LAT-1:0] vld_r;

  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (en) begin
      skid_valid_r <= 1'b0;
    end else if (in_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (!en && !skid_valid_r) skid_r[i] <= in_sum[i];
      if (en) sum_r[i] <= skid_valid_r ? skid_r[i] : in_sum[i];
    end
  end

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], skid_valid_r | in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // maximum and distances below it
  smx_pkg::sum_t  top;
  smx_pkg::dist_t d_r [N];
  always_comb begin
    top = sum_r[0];
    for (int i = 1; i < N; i++) begin
      if (sum_r[i] > top) top = sum_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (en) d_r[i] <= smx_pkg::DIST_W'(top - sum_r[i]);
    end
  end

  // exp lanes
  smx_pkg::prob_t term [N];
  for (genvar i = 0; i < N; i++) begin : g_lane
    smx_exp_lane u_lane (
      .clk  (clk),
      .en   (en),
      .gap  (d_r[i]),
      .beta (beta_r),
      .term (term[i])
    );
  end

  // merge: sum of terms, first normalization
  smx_pkg::tot_t total;
  always_comb begin
    total = '0;
    for (int i = 0; i < N; i++) total = total + smx_pkg::TOT_W'(term[i]);
  end

  smx_pkg::prob_t p1 [N];
  for (genvar i = 0; i < N; i++) begin : g_div1
    smx_pkg::num_t num;
    assign num = {term[i], 16'd0} + smx_pkg::NUM_W'(total[smx_pkg::TOT_W-1:1]);
    smx_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (num),
      .den  (total),
      .quot (p1[i])
    );
  end

  // zero floor: when any entry is zero, raise every entry by one lsb
  logic          any_zero;
  smx_pkg::tot_t s2;
  always_comb begin
    any_zero = 1'b0;
    s2       = '0;
    for (int i = 0; i < N; i++) begin
      if (p1[i] == '0) any_zero = 1'b1;
      s2 = s2 + smx_pkg::TOT_W'(p1[i]) + smx_pkg::TOT_W'(1);
    end
  end

  logic           raise_r;
  smx_pkg::tot_t  s2_r;
  smx_pkg::prob_t p1_r [N];
  always_ff @(posedge clk) begin
    if (en) begin
      raise_r <= any_zero;
      s2_r    <= s2;
      for (int i = 0; i < N; i++) p1_r[i] <= p1[i];
    end
  end

  // second normalization; without a zero entry, dividing by 65536 passes p through
  smx_pkg::tot_t  den2;
  smx_pkg::prob_t p2 [N];
  assign den2 = raise_r ? s2_r : smx_pkg::TOT_W'(65536);

  for (genvar i = 0; i < N; i++) begin : g_div2
    smx_pkg::num_t num;
    assign num = raise_r
        ? {p1_r[i] + smx_pkg::PROB_W'(1), 16'd0} + smx_pkg::NUM_W'(s2_r[smx_pkg::TOT_W-1:1])
        : {p1_r[i], 16'd0} + smx_pkg::NUM_W'(32768);
    smx_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (num),
      .den  (den2),
      .quot (p2[i])
    );
  end

  // output register
  smx_pkg::prob_t prob_r [N];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) prob_r[i] <= p2[i];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_prob_0 = prob_r[0];
  assign out_prob_1 = prob_r[1];
  assign out_prob_2 = prob_r[2];
  assign out_prob_3 = prob_r[3];
  assign out_prob_4 = prob_r[4];

`ifndef SYNTHESIS
  a_skid_only_when_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> !skid_valid_r)
    else $error("skid slot filled while pipe advanced");

  a_max_has_zero_distance: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (d_r[0] == '0 || d_r[1] == '0 || d_r[2] == '0 ||
                  d_r[3] == '0 || d_r[4] == '0))
    else $error("no lane sits at the maximum");

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_prob_0 <= 17'd65536 && out_prob_1 <= 17'd65536 &&
                     out_prob_2 <= 17'd65536 && out_prob_3 <= 17'd65536 &&
                     out_prob_4 <= 17'd65536))
    else $error("probability above one");

  a_frozen_holds_line: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid line moved while frozen");
`endif

endmodule
